// ===== hw/rtl/array_list_insert_delete_search_assert.svh =====
// assertion macros for the list checker
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

`define ALIDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ALIDS_IMPLY(lbl, ante, cons, msg) \
    `ALIDS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/alids_pkg.sv =====
package alids_pkg;

    localparam int CMD_W  = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int END_W  = 5;
    localparam int STAT_W = 2;
    localparam int MPOS_W = 5;
    localparam int CNT_W  = 6;

    localparam int MAX_RES = 32;
    localparam int NM_W    = $clog2(MAX_RES + 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_RANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic idle;
        logic decide;
        logic shift;
        logic put;
        logic srch;
        logic send;
        logic resp;
    } t_ctl;

    typedef struct packed {
        logic dec_srch;
        logic dec_move;
        logic dec_put;
        logic ins;
        logic mv_last;
        logic srch_end;
        logic slot_free;
    } t_sts;

endpackage

// ===== hw/rtl/alids_if.sv =====
interface alids_in_if;
    logic                                valid;
    logic                                ready;
    logic [alids_pkg::CMD_W-1:0]         cmd;
    logic signed [alids_pkg::VAL_W-1:0]  data_value;
    logic [alids_pkg::POS_W-1:0]         position;
    logic [alids_pkg::END_W-1:0]         end_position;

    modport source (output valid, cmd, data_value, position, end_position, input ready);
    modport sink (input valid, cmd, data_value, position, end_position, output ready);
endinterface

interface alids_out_if;
    logic                               valid;
    logic                               ready;
    logic [alids_pkg::STAT_W-1:0]       status;
    logic [alids_pkg::MPOS_W-1:0]       match_position;
    logic [alids_pkg::CNT_W-1:0]        entry_count;
    logic                               last;

    modport source (output valid, status, match_position, entry_count, last, input ready);
    modport sink (input valid, status, match_position, entry_count, last, output ready);
endinterface

// ===== hw/rtl/alids_dp.sv =====
module alids_dp #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alids_pkg::t_ctl                    i_ctl,
    output alids_pkg::t_sts                    o_sts,
    input  logic                               i_in_valid,
    input  logic [alids_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [alids_pkg::VAL_W-1:0] i_data_value,
    input  logic [alids_pkg::POS_W-1:0]        i_position,
    input  logic [alids_pkg::END_W-1:0]        i_end_position,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [alids_pkg::STAT_W-1:0]       o_status,
    output logic [alids_pkg::MPOS_W-1:0]       o_match_position,
    output logic [alids_pkg::CNT_W-1:0]        o_entry_count,
    output logic                               o_last
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int EW = ((CW > alids_pkg::POS_W) ? CW : alids_pkg::POS_W) + 1;
    localparam int XW = (AW > alids_pkg::MPOS_W) ? AW : alids_pkg::MPOS_W;
    localparam int YW = (CW > alids_pkg::CNT_W) ? CW : alids_pkg::CNT_W;
    localparam int NW = alids_pkg::NM_W;
    localparam logic [EW-1:0] ONE   = EW'(1);
    localparam logic [EW-1:0] THREE = EW'(3);
    localparam logic [EW-1:0] DEPTH = EW'(LIST_DEPTH);
    localparam logic [NW-1:0] NM_CAP = NW'(alids_pkg::MAX_RES - 1);

    // entry memory, one write and one registered read per cycle
    logic signed [alids_pkg::VAL_W-1:0] r_mem [LIST_DEPTH];
    logic signed [alids_pkg::VAL_W-1:0] r_rd_data;

    // command beat
    logic [alids_pkg::CMD_W-1:0]        r_cmd;
    logic signed [alids_pkg::VAL_W-1:0] r_value;
    logic [alids_pkg::POS_W-1:0]        r_pos;
    logic [alids_pkg::END_W-1:0]        r_endp;

    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_new_cnt;
    alids_pkg::t_status   r_status;
    logic                 r_put;

    // move walk
    logic [AW-1:0]        r_src;
    logic [AW-1:0]        r_src_end;
    logic [AW-1:0]        r_off;
    logic                 r_up;
    logic                 r_wr_vld;
    logic [AW-1:0]        r_wr_addr;

    // search walk
    logic                        r_issue_done;
    logic                        r_cmp_vld;
    logic [AW-1:0]               r_cmp_idx;
    logic                        r_pend;
    logic [AW-1:0]               r_pend_idx;
    logic [NW-1:0]               r_nm;

    // result register
    logic                                r_o_valid;
    logic [alids_pkg::STAT_W-1:0]        r_o_status;
    logic [alids_pkg::MPOS_W-1:0]        r_o_mpos;
    logic [alids_pkg::CNT_W-1:0]         r_o_cnt;
    logic                                r_o_last;

    logic [EW-1:0]        c;
    logic [EW-1:0]        p;
    logic [EW-1:0]        e;
    logic [EW-1:0]        rmv;
    alids_pkg::t_status   d_status;
    logic [CW-1:0]        d_new_cnt;
    logic                 d_move;
    logic                 d_put;
    logic                 d_srch;
    logic [AW-1:0]        d_src;
    logic [AW-1:0]        d_end;
    logic [AW-1:0]        d_off;
    logic                 d_up;

    logic                 cap_in;
    logic                 slot_free;
    logic                 cmp_hit;
    logic                 stall;
    logic                 rd_en;
    logic                 ld_pend;
    logic                 ld_send;
    logic                 ld_resp;
    logic [XW-1:0]        pend_x;
    logic [YW-1:0]        cnt_x;
    logic [YW-1:0]        new_cnt_x;

    assign cap_in    = i_ctl.idle && i_in_valid;
    assign slot_free = !r_o_valid || i_out_ready;
    assign cmp_hit   = r_cmp_vld && (r_rd_data == r_value);
    assign stall     = cmp_hit && r_pend && !slot_free;
    assign rd_en     = i_ctl.shift || (i_ctl.srch && !stall);
    assign ld_pend   = i_ctl.srch && !stall && cmp_hit && r_pend;
    assign ld_send   = i_ctl.send && slot_free;
    assign ld_resp   = i_ctl.resp && slot_free;
    assign pend_x    = XW'(r_pend_idx);
    assign cnt_x     = YW'(r_cnt);
    assign new_cnt_x = YW'(r_new_cnt);

    // command checks
    always_comb begin
        c         = EW'(r_cnt);
        p         = EW'(r_pos);
        e         = EW'(r_endp);
        rmv       = e - p - ONE;
        d_status  = alids_pkg::ST_OK;
        d_new_cnt = r_cnt;
        d_move    = 1'b0;
        d_put     = 1'b0;
        d_srch    = 1'b0;
        d_src     = '0;
        d_end     = '0;
        d_off     = '0;
        d_up      = 1'b0;
        unique case (r_cmd)
            alids_pkg::CMD_CLEAR: begin
                d_new_cnt = '0;
            end
            alids_pkg::CMD_INSERT: begin
                if (c >= DEPTH) begin
                    d_status = alids_pkg::ST_FULL;
                end else if (p > c) begin
                    d_status = alids_pkg::ST_BADPOS;
                end else begin
                    d_put     = 1'b1;
                    d_new_cnt = CW'(c + ONE);
                    if (p < c) begin
                        d_move = 1'b1;
                        d_src  = AW'(c - ONE);
                        d_end  = AW'(p);
                        d_off  = AW'(ONE);
                    end
                end
            end
            alids_pkg::CMD_DELETE: begin
                if (c == '0 || p >= c) begin
                    d_status = alids_pkg::ST_BADPOS;
                end else begin
                    d_new_cnt = CW'(c - ONE);
                    if (p + ONE < c) begin
                        d_move = 1'b1;
                        d_src  = AW'(p + ONE);
                        d_end  = AW'(c - ONE);
                        d_off  = '1;
                        d_up   = 1'b1;
                    end
                end
            end
            alids_pkg::CMD_DEL_RANGE: begin
                if (c < THREE || p >= c || e >= c || p > e) begin
                    d_status = alids_pkg::ST_BADPOS;
                end else if (e > p + ONE) begin
                    d_new_cnt = CW'(c - rmv);
                    d_move    = 1'b1;
                    d_src     = AW'(e);
                    d_end     = AW'(c - ONE);
                    d_off     = AW'(p + ONE - e);
                    d_up      = 1'b1;
                end
            end
            alids_pkg::CMD_SEARCH: begin
                d_srch = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.dec_srch  = d_srch;
        o_sts.dec_move  = d_move;
        o_sts.dec_put   = d_put;
        o_sts.ins       = r_put;
        o_sts.mv_last   = (r_src == r_src_end);
        o_sts.srch_end  = r_issue_done && !r_cmp_vld;
        o_sts.slot_free = slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_vld) begin
            r_mem[r_wr_addr] <= r_rd_data;
        end else if (i_ctl.put) begin
            r_mem[AW'(r_pos)] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_src];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (cap_in) begin
            r_cmd   <= i_cmd;
            r_value <= i_data_value;
            r_pos   <= i_position;
            r_endp  <= i_end_position;
        end
        if (i_ctl.decide) begin
            r_status  <= d_status;
            r_new_cnt <= d_new_cnt;
            r_put     <= d_put;
            r_src_end <= d_end;
            r_off     <= d_off;
            r_up      <= d_up;
        end
        if (i_ctl.shift) begin
            r_wr_addr <= r_src + r_off;
        end
        if (i_ctl.srch && !stall) begin
            if (!r_issue_done) begin
                r_cmp_idx <= r_src;
            end
            if (cmp_hit) begin
                r_pend_idx <= r_cmp_idx;
            end
        end
        if (ld_pend) begin
            r_o_status <= alids_pkg::ST_OK;
            r_o_mpos   <= pend_x[alids_pkg::MPOS_W-1:0];
            r_o_cnt    <= cnt_x[alids_pkg::CNT_W-1:0];
            r_o_last   <= 1'b0;
        end else if (ld_send) begin
            r_o_status <= r_pend ? alids_pkg::ST_OK : alids_pkg::ST_NOTFOUND;
            r_o_mpos   <= r_pend ? pend_x[alids_pkg::MPOS_W-1:0] : '0;
            r_o_cnt    <= cnt_x[alids_pkg::CNT_W-1:0];
            r_o_last   <= 1'b1;
        end else if (ld_resp) begin
            r_o_status <= r_status;
            r_o_mpos   <= '0;
            r_o_cnt    <= new_cnt_x[alids_pkg::CNT_W-1:0];
            r_o_last   <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_src        <= '0;
            r_wr_vld     <= 1'b0;
            r_issue_done <= 1'b1;
            r_cmp_vld    <= 1'b0;
            r_pend       <= 1'b0;
            r_nm         <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_wr_vld <= i_ctl.shift;
            if (i_ctl.decide) begin
                r_src        <= d_src;
                r_issue_done <= (r_cnt == '0);
                r_cmp_vld    <= 1'b0;
                r_pend       <= 1'b0;
                r_nm         <= '0;
            end else if (i_ctl.shift) begin
                r_src <= r_up ? r_src + AW'(1) : r_src - AW'(1);
            end else if (i_ctl.srch && !stall) begin
                if (!r_issue_done) begin
                    r_cmp_vld    <= 1'b1;
                    r_src        <= r_src + AW'(1);
                    r_issue_done <= (EW'(r_src) + ONE >= EW'(r_cnt));
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                if (cmp_hit) begin
                    r_pend <= 1'b1;
                    r_nm   <= r_nm + NW'(1);
                    // result cap reached, stop the walk
                    if (r_nm == NM_CAP) begin
                        r_issue_done <= 1'b1;
                        r_cmp_vld    <= 1'b0;
                    end
                end
            end
            if (ld_resp) begin
                r_cnt <= r_new_cnt;
            end
            if (ld_pend || ld_send || ld_resp) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_match_position = r_o_mpos;
    assign o_entry_count    = r_o_cnt;
    assign o_last           = r_o_last;

endmodule

// ===== hw/rtl/alids_ctrl.sv =====
module alids_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  alids_pkg::t_sts i_sts,
    output alids_pkg::t_ctl o_ctl
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_SHIFT  = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_PUT    = 8'b0001_0000,
        S_SRCH   = 8'b0010_0000,
        S_SEND   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.dec_srch) begin
                    n_state = S_SRCH;
                end else if (i_sts.dec_move) begin
                    n_state = S_SHIFT;
                end else if (i_sts.dec_put) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (i_sts.mv_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = i_sts.ins ? S_PUT : S_RESP;
            end
            S_PUT: begin
                n_state = S_RESP;
            end
            S_SRCH: begin
                if (i_sts.srch_end) begin
                    n_state = S_SEND;
                end
            end
            S_SEND, S_RESP: begin
                if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl.idle   = (r_state == S_IDLE);
        o_ctl.decide = (r_state == S_DECIDE);
        o_ctl.shift  = (r_state == S_SHIFT);
        o_ctl.put    = (r_state == S_PUT);
        o_ctl.srch   = (r_state == S_SRCH);
        o_ctl.send   = (r_state == S_SEND);
        o_ctl.resp   = (r_state == S_RESP);
    end

endmodule

// ===== hw/rtl/array_list_insert_delete_search.sv =====
// Packed ordered list of up to LIST_DEPTH signed 32-bit entries with a fill count. Each
// command beat (clear, insert, delete at a position, delete between two positions, search)
// is taken only while the block is idle and gives one result beat, except a search, which
// gives one beat per matching position (up to MAX_RES) in ascending order with last on the
// final one, or a single not-found beat. Entries live in a memory with one write port and
// one registered read port; every walk moves or compares one entry per cycle unless the
// search stalls on a full result register. After decode, clear, rejected commands and
// deletes that move nothing go to the result; a delete, range delete or insert that moves
// entries walks them and drains the last write, every insert then writes its value, and a
// search walks the filled entries to its last beat; the result side can stall any beat.
// The next command can be taken in the cycle after the last result beat of the previous
// one is loaded into the output register. No clearing pass runs after reset.
module array_list_insert_delete_search #(
    parameter int LIST_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alids_in_if.sink    i_cmd,
    alids_out_if.source o_rsp
);

    alids_pkg::t_ctl ctl;
    alids_pkg::t_sts sts;

    assign i_cmd.ready = ctl.idle;

    alids_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    alids_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_in_valid       (i_cmd.valid),
        .i_cmd            (i_cmd.cmd),
        .i_data_value     (i_cmd.data_value),
        .i_position       (i_cmd.position),
        .i_end_position   (i_cmd.end_position),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_match_position (o_rsp.match_position),
        .o_entry_count    (o_rsp.entry_count),
        .o_last           (o_rsp.last)
    );

endmodule

// ===== hw/rtl/alids_chk.sv =====
`include "array_list_insert_delete_search_assert.svh"

module alids_chk #(
    parameter int LIST_DEPTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic [alids_pkg::STAT_W-1:0]  i_status,
    input logic [alids_pkg::MPOS_W-1:0]  i_match_position,
    input logic [alids_pkg::CNT_W-1:0]   i_entry_count,
    input logic                          i_out_last
);

    localparam int LIM = (LIST_DEPTH > 63) ? 63 : LIST_DEPTH;
    localparam logic [alids_pkg::CNT_W-1:0] CNT_LIM = LIM[alids_pkg::CNT_W-1:0];

    // a command beat always takes a decode cycle before the next one
    `ALIDS_ASSERT(a_cmd_gap, (i_in_valid && i_in_ready) |=> !i_in_ready, "command beat taken back to back")

    `ALIDS_IMPLY(a_err_last, i_out_valid && i_status != alids_pkg::ST_OK, i_out_last, "error beat not last")

    `ALIDS_IMPLY(a_err_pos, i_out_valid && i_status != alids_pkg::ST_OK, i_match_position == '0, "error beat with position")

    `ALIDS_IMPLY(a_cnt_range, i_out_valid, i_entry_count <= CNT_LIM, "entry count above depth")

endmodule

bind array_list_insert_delete_search alids_chk #(
    .LIST_DEPTH (LIST_DEPTH)
) u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_cmd.valid),
    .i_in_ready       (i_cmd.ready),
    .i_out_valid      (o_rsp.valid),
    .i_status         (o_rsp.status),
    .i_match_position (o_rsp.match_position),
    .i_entry_count    (o_rsp.entry_count),
    .i_out_last       (o_rsp.last)
);
